### hdl/ipfm_pkg.sv
// shared types and constants of the first-match ip rule classifier
`default_nettype none
package ipfm_pkg;

	localparam int ENTRY_COUNT = 64;
	localparam int RULE_COUNT  = 16;
	localparam int SLOT_W      = 6;
	localparam int RULE_W      = 4;
	localparam int KIND_W      = 3;
	localparam int PFX_W       = 8;
	localparam int WORD_W      = 64;
	localparam int V4_W        = 32;
	localparam int V6_W        = 128;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic SIDE_LOC = 1'b0;
	localparam logic SIDE_REM = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_EMPTY    = 3'd0,
		KIND_V4_EXACT = 3'd1,
		KIND_V4_PFX   = 3'd2,
		KIND_V4_RANGE = 3'd3,
		KIND_V6_EXACT = 3'd4,
		KIND_V6_PFX   = 3'd5,
		KIND_V6_RANGE = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_HOLD
	} fsm_t;

	typedef struct packed {
		logic [RULE_W-1:0] rule;
		logic              side;
		logic [KIND_W-1:0] kind;
		logic [PFX_W-1:0]  prefix;
		logic [WORD_W-1:0] start_hi;
		logic [WORD_W-1:0] start_lo;
		logic [WORD_W-1:0] end_hi;
		logic [WORD_W-1:0] end_lo;
	} entry_t;

	typedef struct packed {
		logic [WORD_W-1:0] loc_hi;
		logic [WORD_W-1:0] loc_lo;
		logic              loc_v6;
		logic [WORD_W-1:0] rem_hi;
		logic [WORD_W-1:0] rem_lo;
		logic              rem_v6;
	} key_t;

	typedef struct packed {
		logic [RULE_COUNT-1:0] loc_hits;
		logic [RULE_COUNT-1:0] rem_hits;
	} hit_t;

endpackage
`default_nettype wire

### hdl/ipfm_cell.sv
// one table entry of the chain, matching the key as the walk token passes
`default_nettype none
module ipfm_cell
	import ipfm_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire entry_t wr_entry,
	input  wire key_t   key,
	input  wire logic   tok_in,
	input  wire hit_t   hit_in,
	output logic        tok_out,
	output hit_t        hit_out
);

	logic [RULE_W-1:0] rule_q;
	logic              side_q;
	logic [KIND_W-1:0] kind_q;
	logic [PFX_W-1:0]  prefix_q;
	logic [V6_W-1:0]   start_q;
	logic [V6_W-1:0]   end_q;
	logic              tok_q;
	hit_t              hit_q;

	logic              is_v6;
	logic [V6_W-1:0]   addr;
	logic [V4_W-1:0]   a4, s4, e4, m4;
	logic [V6_W-1:0]   m6;
	logic              hit;
	logic [RULE_COUNT-1:0] rule_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q   <= '0;
			side_q   <= 1'b0;
			kind_q   <= KIND_EMPTY;
			prefix_q <= '0;
		end else if (wr_en) begin
			rule_q   <= wr_entry.rule;
			side_q   <= wr_entry.side;
			kind_q   <= wr_entry.kind;
			prefix_q <= wr_entry.prefix;
		end
	end

	// address words have no reset, only read for written entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_q <= {wr_entry.start_hi, wr_entry.start_lo};
			end_q   <= {wr_entry.end_hi, wr_entry.end_lo};
		end
	end

	always_comb begin
		if (side_q == SIDE_LOC) begin
			is_v6 = key.loc_v6;
			addr  = {key.loc_hi, key.loc_lo};
		end else begin
			is_v6 = key.rem_v6;
			addr  = {key.rem_hi, key.rem_lo};
		end
		a4 = addr[V4_W-1:0];
		s4 = start_q[V4_W-1:0];
		e4 = end_q[V4_W-1:0];
		// zero prefix gives an empty mask and so matches all
		if (prefix_q >= PFX_W'(V4_W)) m4 = '1;
		else                         m4 = ~({V4_W{1'b1}} >> prefix_q[4:0]);
		if (prefix_q >= PFX_W'(V6_W)) m6 = '1;
		else                         m6 = ~({V6_W{1'b1}} >> prefix_q[6:0]);
		case (kind_t'(kind_q))
			KIND_V4_EXACT: hit = !is_v6 && (a4 == s4);
			KIND_V4_PFX:   hit = !is_v6 && ((a4 & m4) == (s4 & m4));
			KIND_V4_RANGE: hit = !is_v6 && (a4 >= s4) && (a4 <= e4);
			KIND_V6_EXACT: hit = is_v6 && (addr == start_q);
			KIND_V6_PFX:   hit = is_v6 && ((addr & m6) == (start_q & m6));
			KIND_V6_RANGE: hit = is_v6 && (addr >= start_q) && (addr <= end_q);
			default:       hit = 1'b0;
		endcase
		rule_bit = '0;
		if (hit && tok_in && (int'(rule_q) < RULE_COUNT))
			rule_bit = RULE_COUNT'(1) << rule_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tok_q <= 1'b0;
		else         tok_q <= tok_in;
	end

	always_ff @(posedge clk) begin
		hit_q.loc_hits <= hit_in.loc_hits | ((side_q == SIDE_LOC) ? rule_bit : '0);
		hit_q.rem_hits <= hit_in.rem_hits | ((side_q == SIDE_REM) ? rule_bit : '0);
	end

	assign tok_out = tok_q;
	assign hit_out = hit_q;

endmodule
`default_nettype wire

### hdl/ip_rule_first_match_classifier_unit.sv
// top level of the first-match ip rule classifier: entry chain, sequencer, result register
`default_nettype none
// The table lives in a chain of ENTRY_COUNT cells, one entry per cell. A write
// transfer loads its cell at once and is acknowledged through the hold state and
// the output register. A lookup transfer latches the address pair, then a token
// walks the chain one cell per cycle carrying per-rule local and remote hit
// flags, and its answer leaves by the hold state and output register. One item is
// in work at a time, but a new one is taken while a finished result still waits
// at the output register. Reset empties the table at once, no clearing pass.
module ip_rule_first_match_classifier_unit
	import ipfm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                action,
	input  wire logic [SLOT_W-1:0]   slot,
	input  wire logic [RULE_W-1:0]   rule_number,
	input  wire logic                side,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [PFX_W-1:0]    prefix_length,
	input  wire logic [WORD_W-1:0]   first_addr_high,
	input  wire logic [WORD_W-1:0]   first_addr_low,
	input  wire logic [WORD_W-1:0]   second_addr_high,
	input  wire logic [WORD_W-1:0]   second_addr_low,
	input  wire logic                local_is_v6,
	input  wire logic                remote_is_v6,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     was_lookup,
	output logic                     found,
	output logic [RULE_W-1:0]        matched_rule
);

	fsm_t state_q, state_nx;
	logic in_acc;
	logic start_q;
	key_t key_q;
	entry_t wr_entry;

	// pending result, waiting for the output register
	logic              res_lookup_q, res_found_q;
	logic [RULE_W-1:0] res_rule_q;

	logic              out_valid_q, out_lookup_q, out_found_q;
	logic [RULE_W-1:0] out_rule_q;
	logic              out_free;

	logic [ENTRY_COUNT:0] tok;
	hit_t                 hit [ENTRY_COUNT+1];

	logic              pe_found;
	logic [RULE_W-1:0] pe_rule;
	logic [RULE_COUNT-1:0] both;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign wr_entry = '{rule: rule_number, side: side, kind: kind, prefix: prefix_length,
		start_hi: first_addr_high, start_lo: first_addr_low,
		end_hi: second_addr_high, end_lo: second_addr_low};

	// lookup key, held for the whole walk
	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_LOOKUP)
			key_q <= '{loc_hi: first_addr_high, loc_lo: first_addr_low, loc_v6: local_is_v6,
				rem_hi: second_addr_high, rem_lo: second_addr_low, rem_v6: remote_is_v6};
	end

	// token enters the chain together with the latched key, the cycle after the lookup is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_q <= 1'b0;
		else         start_q <= in_acc && (action == ACT_LOOKUP);
	end

	assign tok[0] = start_q;
	assign hit[0] = '0;

	for (genvar i = 0; i < ENTRY_COUNT; i++) begin : g_cell
		ipfm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (in_acc && (action == ACT_WRITE) && (int'(slot) == i)),
			.wr_entry (wr_entry),
			.key      (key_q),
			.tok_in   (tok[i]),
			.hit_in   (hit[i]),
			.tok_out  (tok[i+1]),
			.hit_out  (hit[i+1])
		);
	end

	// lowest rule with a hit on both sides
	always_comb begin
		both     = hit[ENTRY_COUNT].loc_hits & hit[ENTRY_COUNT].rem_hits;
		pe_found = 1'b0;
		pe_rule  = '0;
		for (int r = RULE_COUNT - 1; r >= 0; r--) begin
			if (both[r]) begin
				pe_found = 1'b1;
				pe_rule  = RULE_W'(r);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_nx = (action == ACT_LOOKUP) ? ST_WALK : ST_HOLD;
			ST_WALK: if (tok[ENTRY_COUNT]) state_nx = ST_HOLD;
			ST_HOLD: if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			res_lookup_q <= 1'b0;
			res_found_q  <= 1'b0;
			res_rule_q   <= '0;
		end else if (state_q == ST_WALK && tok[ENTRY_COUNT]) begin
			res_lookup_q <= 1'b1;
			res_found_q  <= pe_found;
			res_rule_q   <= pe_rule;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_HOLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			out_lookup_q <= res_lookup_q;
			out_found_q  <= res_found_q;
			out_rule_q   <= res_rule_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign was_lookup   = out_lookup_q;
	assign found        = out_found_q;
	assign matched_rule = out_rule_q;

endmodule
`default_nettype wire

### hdl/ipfm_checker.sv
// port-level checker of the classifier, bound to the top level
`default_nettype none
module ipfm_checker
	import ipfm_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic              was_lookup,
	input wire logic              found,
	input wire logic [RULE_W-1:0] matched_rule
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({was_lookup, found, matched_rule}))
		else $error("stalled result changed");

	// write acknowledge carries no match
	a_ack_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !was_lookup |-> !found && matched_rule == '0)
		else $error("write acknowledge with match fields set");

	// no match reports rule zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> matched_rule == '0)
		else $error("miss with nonzero rule");

	// an accepted item keeps the input side busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous item in work");

endmodule

bind ip_rule_first_match_classifier_unit ipfm_checker u_ipfm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.was_lookup   (was_lookup),
	.found        (found),
	.matched_rule (matched_rule)
);
`default_nettype wire

### test/ip_rule_first_match_classifier_unit_tb.sv
// self-checking testbench of the first-match ip rule classifier
`default_nettype none
module ip_rule_first_match_classifier_unit_tb;
	import ipfm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_WRITE;
	logic [SLOT_W-1:0] slot = '0;
	logic [RULE_W-1:0] rule_number = '0;
	logic side = SIDE_LOC;
	logic [KIND_W-1:0] kind = KIND_EMPTY;
	logic [PFX_W-1:0] prefix_length = '0;
	logic [WORD_W-1:0] first_addr_high = '0, first_addr_low = '0;
	logic [WORD_W-1:0] second_addr_high = '0, second_addr_low = '0;
	logic local_is_v6 = 1'b0, remote_is_v6 = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic was_lookup, found;
	logic [RULE_W-1:0] matched_rule;

	ip_rule_first_match_classifier_unit dut (.*);

	// clock: five units high, five low
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one lookup request or entry write
	typedef struct {
		logic act;
		logic [SLOT_W-1:0] slt;
		logic [RULE_W-1:0] rul;
		logic sd;
		logic [KIND_W-1:0] knd;
		logic [PFX_W-1:0] pfx;
		logic [WORD_W-1:0] ah, al, bh, bl;
		logic av6, bv6;
	} req_t;

	typedef struct {
		logic lk;
		logic fnd;
		logic [RULE_W-1:0] rul;
	} answer_t;

	// private copy of the table, cleared at reset like the block's
	entry_t tbl [ENTRY_COUNT];
	answer_t answers_due[$];
	int mismatches = 0;
	int cycles = 0;
	bit gap_on = 1'b1;
	int burst_left = 0;

	// a 128-bit mask keeping the top n bits
	function automatic logic [V6_W-1:0] top_mask(int n);
		logic [V6_W-1:0] m;
		m = '0;
		for (int i = 0; i < n && i < V6_W; i++) m[V6_W-1-i] = 1'b1;
		return m;
	endfunction

	function automatic bit entry_hit(entry_t en, logic v6, logic [WORD_W-1:0] hi,
			logic [WORD_W-1:0] lo);
		logic [V4_W-1:0] a4, s4, e4, m4;
		logic [V6_W-1:0] a, s, e, m;
		int n;
		a4 = lo[V4_W-1:0];
		s4 = en.start_lo[V4_W-1:0];
		e4 = en.end_lo[V4_W-1:0];
		a = {hi, lo};
		s = {en.start_hi, en.start_lo};
		e = {en.end_hi, en.end_lo};
		n = en.prefix;
		case (en.kind)
			KIND_V4_EXACT: return !v6 && a4 == s4;
			KIND_V4_PFX: begin
				// prefix beyond 32 behaves as a full mask
				m = top_mask(n > V4_W ? V4_W : n);
				m4 = m[V6_W-1 -: V4_W];
				return !v6 && (a4 & m4) == (s4 & m4);
			end
			KIND_V4_RANGE: return !v6 && a4 >= s4 && a4 <= e4;
			KIND_V6_EXACT: return v6 && a == s;
			KIND_V6_PFX: begin
				m = top_mask(n);
				return v6 && (a & m) == (s & m);
			end
			KIND_V6_RANGE: return v6 && s <= a && a <= e;
			default: return 1'b0;
		endcase
	endfunction

	// update the table copy or resolve the first matching rule
	function automatic answer_t classify(req_t r);
		answer_t ans;
		logic [RULE_COUNT-1:0] lh, rh;
		ans = '{1'b0, 1'b0, '0};
		lh = '0;
		rh = '0;
		if (r.act == ACT_WRITE) begin
			tbl[r.slt] = '{r.rul, r.sd, r.knd, r.pfx, r.ah, r.al, r.bh, r.bl};
			return ans;
		end
		ans.lk = 1'b1;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			if (tbl[i].side == SIDE_LOC) begin
				if (entry_hit(tbl[i], r.av6, r.ah, r.al)) lh[tbl[i].rule] = 1'b1;
			end else begin
				if (entry_hit(tbl[i], r.bv6, r.bh, r.bl)) rh[tbl[i].rule] = 1'b1;
			end
		end
		for (int k = 0; k < RULE_COUNT; k++) begin
			if (lh[k] && rh[k]) begin
				ans.fnd = 1'b1;
				ans.rul = k[RULE_W-1:0];
				break;
			end
		end
		return ans;
	endfunction

	// send one item, with bursts and random gaps in front of it
	task automatic send_item(req_t r);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (gap_on) gap = $urandom_range(0, 6);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.act;
		slot <= r.slt;
		rule_number <= r.rul;
		side <= r.sd;
		kind <= r.knd;
		prefix_length <= r.pfx;
		first_addr_high <= r.ah;
		first_addr_low <= r.al;
		second_addr_high <= r.bh;
		second_addr_low <= r.bl;
		local_is_v6 <= r.av6;
		remote_is_v6 <= r.bv6;
		do @(posedge clk); while (in_stall);
		answers_due.push_back(classify(r));
	endtask

	function automatic logic [WORD_W-1:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t rnd_write(int slot_max, int rule_max);
		req_t r;
		r.act = ACT_WRITE;
		r.slt = SLOT_W'($urandom_range(0, slot_max));
		r.rul = RULE_W'($urandom_range(0, rule_max));
		r.sd = 1'($urandom_range(0, 1));
		r.knd = KIND_W'($urandom_range(0, 7));
		r.pfx = ($urandom_range(0, 3) == 0) ? PFX_W'($urandom_range(0, 255)) :
			PFX_W'($urandom_range(0, 40));
		if (r.knd == KIND_V6_PFX) r.pfx = $urandom_range(0, 3) == 0 ?
			PFX_W'($urandom_range(0, 255)) : PFX_W'($urandom_range(0, 130));
		// small address pool so lookups actually hit
		r.ah = $urandom_range(0, 2) == 0 ? rnd64() : 64'($urandom_range(0, 3));
		r.al = $urandom_range(0, 2) == 0 ? rnd64() : 64'($urandom_range(0, 31));
		r.bh = $urandom_range(0, 2) == 0 ? rnd64() : r.ah + 64'($urandom_range(0, 1));
		r.bl = $urandom_range(0, 2) == 0 ? rnd64() : r.al + 64'($urandom_range(0, 20));
		r.av6 = 1'($urandom_range(0, 1));
		r.bv6 = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic req_t rnd_lookup();
		req_t r;
		r = rnd_write(63, 15);
		r.act = ACT_LOOKUP;
		r.ah = $urandom_range(0, 3) == 0 ? rnd64() : 64'($urandom_range(0, 3));
		r.al = $urandom_range(0, 3) == 0 ? rnd64() : 64'($urandom_range(0, 40));
		r.bh = $urandom_range(0, 3) == 0 ? rnd64() : 64'($urandom_range(0, 3));
		r.bl = $urandom_range(0, 3) == 0 ? rnd64() : 64'($urandom_range(0, 40));
		return r;
	endfunction

	function automatic req_t mk(logic a, int s, int ru, logic sd, kind_t k, int p,
			logic [WORD_W-1:0] ah, logic [WORD_W-1:0] al, logic [WORD_W-1:0] bh,
			logic [WORD_W-1:0] bl, logic av, logic bv);
		req_t r;
		r = '{a, SLOT_W'(s), RULE_W'(ru), sd, k, PFX_W'(p), ah, al, bh, bl, av, bv};
		return r;
	endfunction

	// extremes, every entry kind, and the corner cases of matching
	task automatic test_directed();
		logic [WORD_W-1:0] ones;
		ones = '1;
		send_item(mk(ACT_LOOKUP, 0, 0, 0, KIND_EMPTY, 0, 0, 0, 0, 0, 0, 0));
		// zero prefix on both sides, rule 15
		send_item(mk(ACT_WRITE, 63, 15, SIDE_LOC, KIND_V4_PFX, 0, ones, ones, ones, ones, 1, 1));
		send_item(mk(ACT_WRITE, 62, 15, SIDE_REM, KIND_V6_PFX, 0, ones, ones, 0, 0, 0, 0));
		send_item(mk(ACT_LOOKUP, 0, 0, 0, KIND_EMPTY, 0, ones, 64'h1234, ones, ones, 0, 1));
		// family mismatch
		send_item(mk(ACT_LOOKUP, 0, 0, 0, KIND_EMPTY, 0, 0, 0, 0, 0, 1, 0));
		// v4 exact ignoring upper bits, v6 range across the word boundary
		send_item(mk(ACT_WRITE, 0, 3, SIDE_LOC, KIND_V4_EXACT, 0, ones,
			64'hffff_ffff_0a00_0001, 0, 0, 0, 0));
		send_item(mk(ACT_WRITE, 1, 3, SIDE_REM, KIND_V6_RANGE, 0, 64'h1, ones,
			64'h2, 64'h0, 0, 0));
		send_item(mk(ACT_LOOKUP, 0, 0, 0, KIND_EMPTY, 0, 64'h55, 64'h0a00_0001,
			64'h2, 64'h0, 0, 1));
		send_item(mk(ACT_LOOKUP, 0, 0, 0, KIND_EMPTY, 0, 0, 64'h0a00_0001, 64'h2, 64'h1, 0, 1));
		// inverted range, long v4 prefix, v6 exact, v4 range, kind seven
		send_item(mk(ACT_WRITE, 2, 1, SIDE_REM, KIND_V4_RANGE, 0, 0, 64'h20, 0, 64'h10, 0, 0));
		send_item(mk(ACT_WRITE, 3, 1, SIDE_LOC, KIND_V4_PFX, 200, 0, 64'h0a00_0001, 0, 0, 0, 0));
		send_item(mk(ACT_LOOKUP, 0, 0, 0, KIND_EMPTY, 0, 0, 64'h0a00_0001, 0, 64'h18, 0, 0));
		send_item(mk(ACT_WRITE, 4, 0, SIDE_REM, KIND_V6_EXACT, 0, ones, ones, 0, 0, 0, 0));
		send_item(mk(ACT_WRITE, 5, 0, SIDE_LOC, KIND_V4_RANGE, 0, 0, 64'h0a00_0000,
			0, 64'h0a00_00ff, 0, 0));
		send_item(mk(ACT_WRITE, 6, 0, SIDE_LOC, kind_t'(3'd7), 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(ACT_LOOKUP, 63, 15, 1, KIND_V6_RANGE, 255, 0, 64'h0a00_0001, ones, ones, 0, 1));
		// long v6 prefix, then clear the table back to empty
		send_item(mk(ACT_WRITE, 7, 2, SIDE_LOC, KIND_V6_PFX, 255, 64'h8, 64'h9, 0, 0, 0, 0));
		send_item(mk(ACT_LOOKUP, 0, 0, 0, KIND_EMPTY, 0, 64'h8, 64'h9, ones, ones, 1, 1));
		for (int i = 0; i < ENTRY_COUNT; i++)
			send_item(mk(ACT_WRITE, i, 0, SIDE_LOC, KIND_EMPTY, 0, 0, 0, 0, 0, 0, 0));
	endtask

	// mostly short populations of the table followed by lookups
	task automatic test_random(int n);
		int sent, rmax, smax;
		sent = 0;
		while (sent < n) begin
			smax = $urandom_range(0, 3) == 0 ? 63 : 7;
			rmax = $urandom_range(0, 15);
			repeat ($urandom_range(1, 8)) begin
				send_item(rnd_write(smax, rmax));
				sent++;
			end
			repeat ($urandom_range(1, 8)) begin
				send_item(rnd_lookup());
				sent++;
			end
			if ($urandom_range(0, 9) == 0) gap_on = !gap_on;
		end
	endtask

	// receiver stall pattern, with quiet stretches
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles[9:8] == 2'b11) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	// compare each result transfer with the oldest answer due
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer");
			end else begin
				want = answers_due.pop_front();
				if (want.lk !== was_lookup || want.fnd !== found ||
						want.rul !== matched_rule) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want lk=%0d f=%0d r=%0d got lk=%0d f=%0d r=%0d",
							want.lk, want.fnd, want.rul, was_lookup, found, matched_rule);
				end
			end
		end
	end

	// slowest run: lookups that walk the whole chain, under stalls and gaps
	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("FAIL ip_rule_first_match_classifier_unit");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < ENTRY_COUNT; i++) tbl[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(560);
		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (ENTRY_COUNT + 10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS ip_rule_first_match_classifier_unit");
		else
			$display("FAIL ip_rule_first_match_classifier_unit");
		$finish;
	end
endmodule
`default_nettype wire
